/* rtl/core/fbpm_pkg.sv */
// shared types and constants of the frame buffer pool manager
// used by fbpm_ctrl, fbpm_dp and frame_buffer_pool_manager; no dependencies
package fbpm_pkg;

  // field widths of the request and result
  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgW  = 4;

  // entries_in_use after reset
  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  typedef enum logic [CmdW-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_SUBMIT  = 2'd1,
    CMD_RECEIVE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_STATE = 2'd2,
    ST_BAD_ARG   = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the incoming request
    logic exec;     // check and apply push or pop
    logic fetch;    // popped entry is on the ram output
    logic deliver;  // move the result into the output register
  } ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;    // request in exec is a pop that succeeds
    logic out_busy;  // output register holds a result not taken this cycle
  } dp_sts_t;

endpackage

/* rtl/core/frame_buffer_pool_manager.sv */
// top level of the frame buffer pool manager
// depends on fbpm_pkg, fbpm_ctrl, fbpm_dp and fbpm_ram
//
// channel   | dir | ports                         | content
// request   | in  | s_axis_t{valid,ready,data,user} | tdata entry_index, tuser cmd
// result    | out | m_axis_t{valid,ready,data,user} | tdata granted_index, tuser status
// config    | in  | cfg_we_i, cfg_wdata_i          | entries_in_use
//
// a push request goes from accept through exec and done, a pop through fetch too,
// as the list rams read through a register (address in exec, entry in fetch)
// a new request is taken once the previous result sits in the output register
// reset and a count write rebuild the free list at once, no clearing pass
// a stalled output holds the controller in its final state until taken
module frame_buffer_pool_manager #(
  parameter int unsigned POOL_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [2:0] entry_index, [7:3] zero
  input  logic [1:0] s_axis_tuser_i,   // [1:0] cmd
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [2:0] granted_index, [7:3] zero
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);
  fbpm_pkg::ctl_t    ctl;
  fbpm_pkg::dp_sts_t sts;
  logic [fbpm_pkg::IdxW-1:0] granted;

  // sequencing
  fbpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // lists and result register
  fbpm_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (s_axis_tuser_i),
    .entry_index_i   (s_axis_tdata_i[fbpm_pkg::IdxW-1:0]),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .status_o        (m_axis_tuser_o),
    .granted_index_o (granted)
  );

  assign m_axis_tdata_o = {5'd0, granted};

endmodule

/* rtl/core/fbpm_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module fbpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    waddr_i,
  input  logic [Width-1:0]                                wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]    raddr_i,
  output logic [Width-1:0]                                rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fbpm_ctrl.sv */
// controller state machine of the frame buffer pool manager
// depends on fbpm_pkg for the command and status structs
module fbpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  fbpm_pkg::dp_sts_t sts_i,
  output fbpm_pkg::ctl_t    ctl_o
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_DONE
  } state_e;

  state_e state_q;
  logic   tready_q;

  // command decode from the current state
  always_comb begin
    ctl_o         = '0;
    ctl_o.load    = tready_q & s_tvalid_i;
    ctl_o.exec    = (state_q == S_EXEC);
    ctl_o.fetch   = (state_q == S_FETCH);
    ctl_o.deliver = (state_q == S_DONE) & ~sts_i.out_busy;
  end

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tready_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          tready_q <= 1'b1;
          if (tready_q && s_tvalid_i) begin
            state_q  <= S_EXEC;
            tready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= sts_i.pop_ok ? S_FETCH : S_DONE;
        end
        S_FETCH: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!sts_i.out_busy) begin
            state_q  <= S_IDLE;
            tready_q <= 1'b1;
          end
        end
        default: begin
          state_q  <= S_IDLE;
          tready_q <= 1'b0;
        end
      endcase
    end
  end

  assign s_tready_o = tready_q;

endmodule

/* rtl/core/fbpm_dp.sv */
// datapath of the frame buffer pool manager: lists, counts, checked-out bits
// depends on fbpm_pkg and fbpm_ram
module fbpm_dp #(
  parameter int unsigned POOL_DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbpm_pkg::ctl_t              ctl_i,
  output fbpm_pkg::dp_sts_t           sts_o,
  input  logic [fbpm_pkg::CmdW-1:0]   cmd_i,
  input  logic [fbpm_pkg::IdxW-1:0]   entry_index_i,
  input  logic                        cfg_we_i,
  input  logic [fbpm_pkg::CfgW-1:0]   cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fbpm_pkg::StatW-1:0]  status_o,
  output logic [fbpm_pkg::IdxW-1:0]   granted_index_o
);
  localparam int unsigned EntW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned AddrW = EntW;
  localparam int unsigned CntW  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned WideW = (CntW > fbpm_pkg::CfgW) ? CntW : fbpm_pkg::CfgW;
  localparam int unsigned ResetCount = (POOL_DEPTH < 8) ? POOL_DEPTH : 8;

  // architectural state
  logic [fbpm_pkg::CfgW-1:0] cfg_q;
  logic [CntW-1:0]           free_cnt_q, ready_cnt_q;
  logic [CntW-1:0]           wmin_q;  // free positions below this still hold their own index
  logic [POOL_DEPTH-1:0]     co_q;

  // request and result registers
  fbpm_pkg::cmd_e            cmd_q;
  logic [fbpm_pkg::IdxW-1:0] idx_q;
  fbpm_pkg::status_e         pend_status_q, out_status_q;
  logic [EntW-1:0]           pend_grant_q, out_grant_q;
  logic [CntW-1:0]           rd_pos_q;
  logic                      rd_free_q;
  logic                      out_valid_q;

  // effective count from the register and from a new write
  logic [CntW-1:0] n_cur, n_new;

  function automatic logic [CntW-1:0] clamp_count(input logic [fbpm_pkg::CfgW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (WideW'(v) > WideW'(POOL_DEPTH)) begin
      r = CntW'(POOL_DEPTH);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

  assign n_cur = clamp_count(cfg_q);
  assign n_new = clamp_count(cfg_wdata_i);

  // operation decode
  logic            is_pop, use_free;
  logic [CntW-1:0] cnt_sel, pos_dec;
  logic [WideW-1:0] idx_w;
  logic [EntW-1:0] idx_e;

  assign is_pop   = cmd_q inside {fbpm_pkg::CMD_ACQUIRE, fbpm_pkg::CMD_RECEIVE};
  assign use_free = cmd_q inside {fbpm_pkg::CMD_ACQUIRE, fbpm_pkg::CMD_RELEASE};
  assign cnt_sel  = use_free ? free_cnt_q : ready_cnt_q;
  assign pos_dec  = cnt_sel - CntW'(1);
  assign idx_w    = WideW'(idx_q);
  assign idx_e    = EntW'(idx_q);

  // checks of the request in exec
  fbpm_pkg::status_e ex_status;
  logic              ex_pop_ok, ex_push_ok;

  always_comb begin
    ex_status  = fbpm_pkg::ST_OK;
    ex_pop_ok  = 1'b0;
    ex_push_ok = 1'b0;
    if (is_pop) begin
      if (cnt_sel == '0) begin
        ex_status = fbpm_pkg::ST_EMPTY;
      end else begin
        ex_pop_ok = 1'b1;
      end
    end else if (idx_w >= WideW'(n_cur)) begin
      ex_status = fbpm_pkg::ST_BAD_ARG;
    end else if (!co_q[idx_e]) begin
      ex_status = fbpm_pkg::ST_BAD_STATE;
    end else if (cnt_sel >= CntW'(POOL_DEPTH)) begin
      ex_status = fbpm_pkg::ST_BAD_STATE;
    end else begin
      ex_push_ok = 1'b1;
    end
  end

  // list storage
  logic            free_we, ready_we;
  logic [EntW-1:0] free_rdata, ready_rdata;

  assign free_we  = ctl_i.exec & ex_push_ok & use_free & ~cfg_we_i;
  assign ready_we = ctl_i.exec & ex_push_ok & ~use_free & ~cfg_we_i;

  fbpm_ram #(
    .Width (EntW),
    .Depth (POOL_DEPTH)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (AddrW'(cnt_sel)),
    .wdata_i (idx_e),
    .raddr_i (AddrW'(pos_dec)),
    .rdata_o (free_rdata)
  );

  fbpm_ram #(
    .Width (EntW),
    .Depth (POOL_DEPTH)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (ready_we),
    .waddr_i (AddrW'(cnt_sel)),
    .wdata_i (idx_e),
    .raddr_i (AddrW'(pos_dec)),
    .rdata_o (ready_rdata)
  );

  // popped entry, untouched free positions read as their own index
  logic [EntW-1:0] fetch_entry;

  always_comb begin
    if (!rd_free_q) begin
      fetch_entry = ready_rdata;
    end else if (rd_pos_q < wmin_q) begin
      fetch_entry = EntW'(rd_pos_q);
    end else begin
      fetch_entry = free_rdata;
    end
  end

  // control state, a count write rebuilds the lists
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= fbpm_pkg::CfgReset;
      free_cnt_q  <= CntW'(ResetCount);
      ready_cnt_q <= '0;
      wmin_q      <= CntW'(POOL_DEPTH);
      co_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cfg_q       <= cfg_wdata_i;
        free_cnt_q  <= n_new;
        ready_cnt_q <= '0;
        wmin_q      <= CntW'(POOL_DEPTH);
        co_q        <= '0;
      end else begin
        if (ctl_i.exec && ex_push_ok) begin
          co_q[idx_e] <= 1'b0;
          if (use_free) begin
            free_cnt_q <= cnt_sel + CntW'(1);
            if (cnt_sel < wmin_q) begin
              wmin_q <= cnt_sel;
            end
          end else begin
            ready_cnt_q <= cnt_sel + CntW'(1);
          end
        end
        if (ctl_i.exec && ex_pop_ok) begin
          if (use_free) begin
            free_cnt_q <= pos_dec;
          end else begin
            ready_cnt_q <= pos_dec;
          end
        end
        if (ctl_i.fetch) begin
          co_q[fetch_entry] <= 1'b1;
        end
      end
    end
  end

  // request capture and result path
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= fbpm_pkg::cmd_e'(cmd_i);
      idx_q <= entry_index_i;
    end
    if (ctl_i.exec) begin
      pend_status_q <= ex_status;
      pend_grant_q  <= '0;
      rd_pos_q      <= pos_dec;
      rd_free_q     <= use_free;
    end
    if (ctl_i.fetch) begin
      pend_grant_q <= fetch_entry;
    end
    if (ctl_i.deliver) begin
      out_status_q <= pend_status_q;
      out_grant_q  <= pend_grant_q;
    end
  end

  assign sts_o.pop_ok   = ex_pop_ok;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = fbpm_pkg::IdxW'(out_grant_q);

  // free and ready lists together never hold more entries than the pool
  a_lists_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WideW + 1)'(free_cnt_q) + (WideW + 1)'(ready_cnt_q) <= (WideW + 1)'(POOL_DEPTH))
    else $error("free and ready lists together exceed the pool");

  // a popped entry is never one that is already checked out
  a_pop_not_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fetch && !cfg_we_i |-> !co_q[fetch_entry])
    else $error("popped entry was already checked out");

  // a count write leaves a fresh free list and nothing checked out
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> ready_cnt_q == '0 && co_q == '0 && free_cnt_q == $past(n_new))
    else $error("list rebuild after count write incomplete");

endmodule

/* dv/frame_buffer_pool_manager_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of frame_buffer_pool_manager: directed and random requests, with count
// register writes between phases; depends on fbpm_pkg and the frame_buffer_pool_manager rtl
module frame_buffer_pool_manager_test;

  localparam int unsigned Depth = 8;
  localparam int unsigned IdxW  = fbpm_pkg::IdxW;

  typedef struct packed {
    fbpm_pkg::status_e status;
    logic [IdxW-1:0]   index;
  } grant_t;

  // tracks free list, ready list and checked-out bits, holds the grants still to come
  class pool_tracker;
    int unsigned      n_entries;
    logic [IdxW-1:0]  free_stk[Depth];
    logic [IdxW-1:0]  ready_stk[Depth];
    int unsigned      free_top;
    int unsigned      ready_top;
    logic [Depth-1:0] out_bits;
    grant_t           pending_grants[$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
      rebuild(fbpm_pkg::CfgReset);
    endfunction

    // count clamped to 1..Depth, free list 0..count-1 with the highest on top
    function void rebuild(logic [fbpm_pkg::CfgW-1:0] count);
      if (count < 1) n_entries = 1;
      else if (count > Depth) n_entries = Depth;
      else n_entries = 32'(count);
      for (int i = 0; i < Depth; i++) begin
        free_stk[i]  = (i < n_entries) ? IdxW'(i) : '0;
        ready_stk[i] = '0;
      end
      free_top  = n_entries;
      ready_top = 0;
      out_bits  = '0;
    endfunction

    // push onto the ready list or the free list
    function fbpm_pkg::status_e push(bit to_ready, logic [IdxW-1:0] idx);
      if (idx >= n_entries) return fbpm_pkg::ST_BAD_ARG;
      if (!out_bits[idx]) return fbpm_pkg::ST_BAD_STATE;
      if ((to_ready ? ready_top : free_top) >= Depth) return fbpm_pkg::ST_BAD_STATE;
      out_bits[idx] = 1'b0;
      if (to_ready) begin
        ready_stk[ready_top] = idx;
        ready_top++;
      end else begin
        free_stk[free_top] = idx;
        free_top++;
      end
      return fbpm_pkg::ST_OK;
    endfunction

    // pop from the ready list or the free list and check the entry out
    function fbpm_pkg::status_e pop(bit from_ready, output logic [IdxW-1:0] idx);
      idx = '0;
      if (from_ready) begin
        if (ready_top == 0) return fbpm_pkg::ST_EMPTY;
        ready_top--;
        idx = ready_stk[ready_top];
      end else begin
        if (free_top == 0) return fbpm_pkg::ST_EMPTY;
        free_top--;
        idx = free_stk[free_top];
      end
      out_bits[idx] = 1'b1;
      return fbpm_pkg::ST_OK;
    endfunction

    function void note_request(fbpm_pkg::cmd_e cmd, logic [IdxW-1:0] idx);
      grant_t          g;
      logic [IdxW-1:0] got;
      got = '0;
      case (cmd)
        fbpm_pkg::CMD_ACQUIRE: g.status = pop(1'b0, got);
        fbpm_pkg::CMD_SUBMIT:  g.status = push(1'b1, idx);
        fbpm_pkg::CMD_RECEIVE: g.status = pop(1'b1, got);
        default:               g.status = push(1'b0, idx);
      endcase
      g.index = (g.status == fbpm_pkg::ST_OK) ? got : '0;
      pending_grants.push_back(g);
    endfunction

    function void flag(string what, grant_t want, fbpm_pkg::status_e st,
                       logic [IdxW-1:0] idx);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected status %0d index %0d, got status %0d index %0d",
                 $time, what, want.status, want.index, st, idx);
    endfunction

    function void check_result(fbpm_pkg::status_e st, logic [IdxW-1:0] idx);
      grant_t want;
      results_seen++;
      if (pending_grants.size() == 0) begin
        want = '0;
        flag("result with no request waiting", want, st, idx);
        return;
      end
      want = pending_grants.pop_front();
      if (want.status !== st || want.index !== idx) flag("wrong result", want, st, idx);
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       s_tvalid  = 1'b0;
  logic [7:0] s_tdata   = '0;
  logic [1:0] s_tuser   = '0;
  logic       m_tready  = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = '0;

  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  pool_tracker tracker = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned requests_sent  = 0;
  int unsigned count_writes   = 0;

  frame_buffer_pool_manager #(
    .POOL_DEPTH(Depth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #2 clk = ~clk;

  // result side: random stalls, checked at the rising edge
  always @(negedge clk) begin
    m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o === 1'b1 && m_tready)
      tracker.check_result(fbpm_pkg::status_e'(m_axis_tuser_o), m_axis_tdata_o[IdxW-1:0]);
  end

  // one request, with random idle cycles ahead of it; starts and ends at a falling edge
  task automatic send_request(fbpm_pkg::cmd_e cmd, logic [IdxW-1:0] idx);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, idx};
    do @(posedge clk); while (s_axis_tready_o !== 1'b1);
    tracker.note_request(cmd, idx);
    requests_sent++;
    @(negedge clk);
  endtask

  // mostly legal sequences: pushes usually name an entry that is checked out
  task automatic random_request();
    int unsigned      r;
    fbpm_pkg::cmd_e   cmd;
    logic [IdxW-1:0]  idx;
    logic [Depth-1:0] held;
    r    = $urandom_range(99);
    cmd  = (r < 30) ? fbpm_pkg::CMD_ACQUIRE :
           (r < 55) ? fbpm_pkg::CMD_SUBMIT  :
           (r < 78) ? fbpm_pkg::CMD_RECEIVE : fbpm_pkg::CMD_RELEASE;
    idx  = IdxW'($urandom_range(7));
    held = tracker.out_bits;
    if ((cmd == fbpm_pkg::CMD_SUBMIT || cmd == fbpm_pkg::CMD_RELEASE) && held != '0 &&
        $urandom_range(99) < 80)
      do idx = IdxW'($urandom_range(7)); while (!held[idx]);
    send_request(cmd, idx);
  endtask

  // count write once every result is out and the block has settled
  task automatic write_count(logic [3:0] value);
    s_tvalid <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.rebuild(value);
    count_writes++;
  endtask

  initial begin
    logic [3:0] phase_count[8];
    phase_count = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd5, 4'(9 + $urandom_range(5)), 4'd3,
                    4'(2 + $urandom_range(5))};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of eight: empty ready list, push of an entry not checked out
    send_request(fbpm_pkg::CMD_RECEIVE, 3'd0);
    send_request(fbpm_pkg::CMD_SUBMIT, 3'd0);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd5);
    send_request(fbpm_pkg::CMD_SUBMIT, 3'd7);
    send_request(fbpm_pkg::CMD_RECEIVE, 3'd3);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd7);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd7);

    // two entries: index out of range ahead of state check, both lists run dry
    write_count(4'd2);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd6);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd0);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd7);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd0);
    send_request(fbpm_pkg::CMD_SUBMIT, 3'd1);
    send_request(fbpm_pkg::CMD_SUBMIT, 3'd0);
    send_request(fbpm_pkg::CMD_SUBMIT, 3'd2);
    send_request(fbpm_pkg::CMD_RECEIVE, 3'd0);
    send_request(fbpm_pkg::CMD_RECEIVE, 3'd0);
    send_request(fbpm_pkg::CMD_RECEIVE, 3'd0);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd0);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd1);

    // count of zero acts as one
    write_count(4'd0);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd0);
    send_request(fbpm_pkg::CMD_ACQUIRE, 3'd0);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd1);
    send_request(fbpm_pkg::CMD_RELEASE, 3'd0);

    // random phases, idling pattern cycling through the four modes
    for (int p = 0; p < 8; p++) begin
      write_count(phase_count[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      repeat (200) random_request();
    end

    s_tvalid <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d count writes, counts 0 to 15",
             requests_sent, tracker.results_seen, count_writes);
    if (tracker.mismatches == 0 && tracker.pending_grants.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results outstanding", tracker.mismatches,
               tracker.pending_grants.size());
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", tracker.pending_grants.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
